@@ rtl/pidwc_pkg.sv @@
// shared types, constants and helpers of the pid controller with windup clamp
package pidwc_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int DT_W       = 20;
   localparam int OPD_W      = 33;
   localparam int PROD_W     = 2 * OPD_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int DIV_W      = 53;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int ADDR_W     = 5;
   localparam int RCP_SHIFT  = 19;

   localparam logic [DT_W-1:0] US_PER_SEC = DT_W'(1000000);

   // reciprocal of one million scaled by 2^(RCP_SHIFT+DATA_W)
   localparam logic [DATA_W-1:0] RECIP_US =
      DATA_W'((64'd1 << (RCP_SHIFT + DATA_W)) / 64'd1000000);
   localparam logic [DIV_W-1:0]  US_1X = DIV_W'(1000000);
   localparam logic [DIV_W-1:0]  US_2X = DIV_W'(2000000);
   localparam logic [DIV_W-1:0]  US_3X = DIV_W'(3000000);

   typedef enum logic [1:0] {
      OP_MEAS     = 2'd0,
      OP_SETPOINT = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_WINDUP   = 3'd3,
      REG_BIAS     = 3'd4,
      REG_LOOP     = 3'd5,
      REG_SPARE6   = 3'd6,
      REG_SPARE7   = 3'd7
   } reg_type;

   typedef enum logic [2:0] {
      MUL_ERR_DT,
      MUL_RECIP,
      MUL_QEST_US,
      MUL_DIFF_US,
      MUL_GAIN_P,
      MUL_GAIN_I,
      MUL_GAIN_D
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_BIAS
   } acc_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_IDT,
      ST_RCP_MUL,
      ST_RCP_BACK,
      ST_RCP_FIX,
      ST_INT,
      ST_MUL_DUS,
      ST_DIV_D_START,
      ST_DIV_D_WAIT,
      ST_DERIV,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_OUT,
      ST_OUT_SP
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic [DATA_W-2:0]        windup_limit;
      logic signed [DATA_W-1:0] output_bias;
      logic                     loop_closed;
   } cfg_type;

   typedef struct packed {
      logic        capture;
      logic        err_load;
      logic        set_target;
      logic        clear_state;
      logic        set_armed;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        rcp_load;
      logic        qest_load;
      logic        quo_fix;
      logic        div_start;
      logic        int_update;
      logic        deriv_update;
      acc_op_type  acc_op;
      logic        out_load;
      logic        out_open;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   armed;
      logic   loop_closed;
      logic   div_busy;
      logic   out_free;
   } sts_type;

   function automatic logic signed [DATA_W-1:0] sat_to_data(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (x > hi) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

@@ rtl/pidwc_csr.sv @@
// configuration registers on the apb-style port
module pidwc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pidwc_pkg::ADDR_W-1:0]     paddr,
   input  logic [pidwc_pkg::DATA_W-1:0]     pwdata,
   output logic [pidwc_pkg::DATA_W-1:0]     prdata,
   output logic                             pready,
   output pidwc_pkg::cfg_type               cfg
);
   import pidwc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   reg_type idx;
   logic    wr_en;

   assign pready = 1'b1;
   assign idx    = reg_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_GAIN_P: cfg_in.gain_p       = pwdata;
            REG_GAIN_I: cfg_in.gain_i       = pwdata;
            REG_GAIN_D: cfg_in.gain_d       = pwdata;
            REG_WINDUP: cfg_in.windup_limit = pwdata[DATA_W-2:0];
            REG_BIAS:   cfg_in.output_bias  = pwdata;
            REG_LOOP:   cfg_in.loop_closed  = pwdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_GAIN_P: prdata = cfg_ff.gain_p;
         REG_GAIN_I: prdata = cfg_ff.gain_i;
         REG_GAIN_D: prdata = cfg_ff.gain_d;
         REG_WINDUP: prdata = {1'b0, cfg_ff.windup_limit};
         REG_BIAS:   prdata = cfg_ff.output_bias;
         REG_LOOP:   prdata = {{(DATA_W-1){1'b0}}, cfg_ff.loop_closed};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/pidwc_div.sv @@
// serial restoring divider, signed dividend truncated toward zero, one bit per cycle
module pidwc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pidwc_pkg::DIV_W:0]    dividend,
   input  logic [pidwc_pkg::DT_W-1:0]          divisor,
   output logic                                busy,
   output logic signed [pidwc_pkg::DIV_W:0]    quotient
);
   import pidwc_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DT_W-1:0]      rem_ff, rem_in;
   logic [DT_W-1:0]      den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic signed [DIV_W:0] mag;
   logic [DT_W:0]        shifted;
   logic [DT_W:0]        diff;

   assign mag     = dividend[DIV_W] ? -dividend : dividend;
   assign shifted = {rem_ff, num_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = mag[DIV_W-1:0];
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[DIV_W];
      end else if (busy_ff) begin
         if (!diff[DT_W]) begin
            rem_in = diff[DT_W-1:0];
            num_in = {num_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DT_W-1:0];
            num_in = {num_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});

endmodule

@@ rtl/pidwc_dp.sv @@
// datapath: controller state, shared multiplier, divider, accumulator and result register
module pidwc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  pidwc_pkg::cfg_type                 cfg,
   input  pidwc_pkg::cmd_type                 cmd,
   output pidwc_pkg::sts_type                 sts,
   input  logic [1:0]                         req_operation,
   input  logic signed [pidwc_pkg::DATA_W-1:0] req_value,
   input  logic [pidwc_pkg::DT_W-1:0]         req_elapsed_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pidwc_pkg::DATA_W-1:0] rsp_control_out,
   output logic                               rsp_open_loop
);
   import pidwc_pkg::*;

   op_type                   op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [DATA_W-1:0] target_ff, integ_ff, deriv_ff, prev_ff, err_ff;
   logic                     armed_ff;
   logic signed [PROD_W-1:0] mulr_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic                     rsp_open_ff;
   logic [DIV_W-1:0]         mag_ff;
   logic [DATA_W-1:0]        qest_ff;
   logic signed [DATA_W+1:0] iq_ff;

   logic signed [DATA_W:0]   err_wide;
   logic signed [OPD_W-1:0]  err_mag;
   logic signed [OPD_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0]  term;
   logic signed [DIV_W:0]    quot;
   logic                     div_busy;
   logic signed [DIV_W+1:0]  int_sum;
   logic signed [DIV_W+1:0]  lim_pos;
   logic signed [DIV_W+1:0]  lim_neg;
   logic signed [DATA_W-1:0] int_next;
   logic [DIV_W-1:0]         rem_us;
   logic [1:0]               corr;
   logic [DATA_W:0]          q_mag;

   assign err_wide = $signed({target_ff[DATA_W-1], target_ff}) -
                     $signed({value_ff[DATA_W-1], value_ff});

   assign err_mag = err_ff[DATA_W-1] ? -OPD_W'(err_ff) : OPD_W'(err_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = err_mag;
            mul_b = $signed({{(OPD_W-DT_W){1'b0}}, dt_ff});
         end
         MUL_RECIP: begin
            mul_a = $signed({1'b0, mulr_ff[RCP_SHIFT+DATA_W-1:RCP_SHIFT]});
            mul_b = $signed({1'b0, RECIP_US});
         end
         MUL_QEST_US: begin
            mul_a = $signed({1'b0, mulr_ff[2*DATA_W-1:DATA_W]});
            mul_b = $signed({{(OPD_W-DT_W){1'b0}}, US_PER_SEC});
         end
         MUL_DIFF_US: begin
            mul_a = OPD_W'(err_ff) - OPD_W'(prev_ff);
            mul_b = $signed({{(OPD_W-DT_W){1'b0}}, US_PER_SEC});
         end
         MUL_GAIN_P: begin
            mul_a = OPD_W'(cfg.gain_p);
            mul_b = OPD_W'(err_ff);
         end
         MUL_GAIN_I: begin
            mul_a = OPD_W'(cfg.gain_i);
            mul_b = OPD_W'(integ_ff);
         end
         MUL_GAIN_D: begin
            mul_a = OPD_W'(cfg.gain_d);
            mul_b = OPD_W'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pidwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mulr_ff[DIV_W:0]),
      .divisor  (dt_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   // reciprocal estimate is low by at most a few, fixed up by compare
   assign rem_us = mag_ff - mulr_ff[DIV_W-1:0];
   always_comb begin
      if (rem_us >= US_3X) begin
         corr = 2'd3;
      end else if (rem_us >= US_2X) begin
         corr = 2'd2;
      end else if (rem_us >= US_1X) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
   end
   assign q_mag = {1'b0, qest_ff} + (DATA_W+1)'(corr);

   // integral step with windup clamp
   assign lim_pos = $signed({{(DIV_W+2-(DATA_W-1)){1'b0}}, cfg.windup_limit});
   assign lim_neg = -lim_pos;
   assign int_sum = (DIV_W+2)'(integ_ff) + (DIV_W+2)'(iq_ff);
   always_comb begin
      if (int_sum > lim_pos) begin
         int_next = lim_pos[DATA_W-1:0];
      end else if (int_sum < lim_neg) begin
         int_next = lim_neg[DATA_W-1:0];
      end else begin
         int_next = int_sum[DATA_W-1:0];
      end
   end

   // gain product scaled back, floor rounding
   assign term = ACC_W'(mulr_ff >>> FRAC_BITS);

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:     acc_in = term;
         ACC_ADD:      acc_in = acc_ff + term;
         ACC_ADD_BIAS: acc_in = acc_ff + term + ACC_W'(cfg.output_bias);
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         integ_ff     <= '0;
         deriv_ff     <= '0;
         prev_ff      <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_target) begin
            target_ff <= value_ff;
         end
         if (cmd.clear_state) begin
            integ_ff <= '0;
            deriv_ff <= '0;
            prev_ff  <= '0;
            armed_ff <= 1'b0;
         end else begin
            if (cmd.set_armed) begin
               armed_ff <= 1'b1;
            end
            if (cmd.int_update) begin
               integ_ff <= int_next;
            end
            if (cmd.deriv_update) begin
               deriv_ff <= sat_to_data(ACC_W'(quot));
               prev_ff  <= err_ff;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
         dt_ff    <= (req_elapsed_us == '0) ? DT_W'(1) : req_elapsed_us;
      end
      if (cmd.err_load) begin
         err_ff <= sat_to_data(ACC_W'(err_wide));
      end
      if (cmd.mul_en) begin
         mulr_ff <= mul_a * mul_b;
      end
      if (cmd.rcp_load) begin
         mag_ff <= mulr_ff[DIV_W-1:0];
      end
      if (cmd.qest_load) begin
         qest_ff <= mulr_ff[2*DATA_W-1:DATA_W];
      end
      if (cmd.quo_fix) begin
         iq_ff <= err_ff[DATA_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
      end
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         rsp_data_ff <= cmd.out_open ? target_ff : sat_to_data(acc_ff);
         rsp_open_ff <= cmd.out_open;
      end
   end

   assign sts.op          = op_ff;
   assign sts.armed       = armed_ff;
   assign sts.loop_closed = cfg.loop_closed;
   assign sts.div_busy    = div_busy;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_control_out = rsp_data_ff;
   assign rsp_open_loop   = rsp_open_ff;

endmodule

@@ rtl/pidwc_ctrl.sv @@
// controller state machine sequencing the datapath per beat
module pidwc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pidwc_pkg::sts_type sts,
   output pidwc_pkg::cmd_type cmd
);
   import pidwc_pkg::*;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_ERR_DT;
      cmd.acc_op  = ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.err_load = 1'b1;
            case (sts.op)
               OP_MEAS: begin
                  if (sts.armed) begin
                     state_in = ST_MUL_IDT;
                  end else begin
                     cmd.set_armed = 1'b1;
                     state_in      = ST_MUL_P;
                  end
               end
               OP_SETPOINT: begin
                  cmd.set_target = 1'b1;
                  state_in = sts.loop_closed ? ST_IDLE : ST_OUT_SP;
               end
               OP_CLEAR: begin
                  cmd.clear_state = 1'b1;
                  state_in        = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MUL_IDT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_DT;
            state_in    = ST_RCP_MUL;
         end
         ST_RCP_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_RECIP;
            cmd.rcp_load = 1'b1;
            state_in     = ST_RCP_BACK;
         end
         ST_RCP_BACK: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_QEST_US;
            cmd.qest_load = 1'b1;
            state_in      = ST_RCP_FIX;
         end
         ST_RCP_FIX: begin
            cmd.quo_fix = 1'b1;
            state_in    = ST_INT;
         end
         ST_INT: begin
            cmd.int_update = 1'b1;
            state_in       = ST_MUL_DUS;
         end
         ST_MUL_DUS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIFF_US;
            state_in    = ST_DIV_D_START;
         end
         ST_DIV_D_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_D_WAIT;
         end
         ST_DIV_D_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_DERIV;
            end
         end
         ST_DERIV: begin
            cmd.deriv_update = 1'b1;
            state_in         = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_P;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_I;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_D;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc_op = ACC_ADD_BIAS;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_SP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_open = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/pid_controller_windup_clamp_core.sv @@
// top level of the pid controller with integral windup clamp
// Input channel (req_): one beat carries an operation (measurement, setpoint
// update or clear), a signed Q16.16 value and the elapsed time in microseconds.
// Result channel (rsp_): one beat per measurement, and one per setpoint update
// while the loop is open (open_loop set, setpoint passed through unbiased).
// Gains, windup limit, bias and loop mode are written over the apb-style port;
// the user must write them only while idle; the block does not enforce this.
// For an armed measurement most of the time goes to the serial divider for the
// derivative; the integral step instead multiplies by a reciprocal on the shared
// multiplier. The first measurement after a clear only arms timing and skips the
// integral and derivative steps. A clear or a closed-loop setpoint is done after
// the decode step, an open-loop setpoint update once its output is loaded.
// One item is in work at a time; req_stall stays high until it is done. A new
// item is accepted while a finished result still waits in the output register.
// If the receiver stalls, the result holds, and the next result waits for it.
// Reset (synchronous) clears the configuration, controller state and the output valid.
module pid_controller_windup_clamp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic signed [pidwc_pkg::DATA_W-1:0] req_value,
   input  logic [pidwc_pkg::DT_W-1:0]          req_elapsed_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pidwc_pkg::DATA_W-1:0] rsp_control_out,
   output logic                                rsp_open_loop,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pidwc_pkg::ADDR_W-1:0]        paddr,
   input  logic [pidwc_pkg::DATA_W-1:0]        pwdata,
   output logic [pidwc_pkg::DATA_W-1:0]        prdata,
   output logic                                pready
);
   import pidwc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   pidwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pidwc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_elapsed_us  (req_elapsed_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_control_out (rsp_control_out),
      .rsp_open_loop   (rsp_open_loop)
   );

endmodule

@@ rtl/pidwc_checker.sv @@
// port-level checker for the pid controller, bound to the top level
module pidwc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [pidwc_pkg::DATA_W-1:0] rsp_control_out,
   input logic                                rsp_open_loop
);
   import pidwc_pkg::*;

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_control_out)
                                 && $stable(rsp_open_loop))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while previous item in work");

   // no result can rise in the cycle after an accept
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // reset leaves no result and an idle input side
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind pid_controller_windup_clamp_core pidwc_checker u_pidwc_checker (.*);

@@ dv/pid_controller_windup_clamp_core_tb.sv @@
// testbench of the pid controller with windup clamp: random and directed beats against a predictor
`timescale 1ns / 100ps

module pid_controller_windup_clamp_core_tb;
   import pidwc_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;

   typedef struct packed {
      logic signed [31:0] control_out;
      logic               open_loop;
   } ctl_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic signed [31:0] req_value = '0;
   logic [19:0] req_elapsed_us = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [31:0] rsp_control_out;
   logic rsp_open_loop;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   pid_controller_windup_clamp_core DUT (.*);

   always #6 clock = ~clock;

   // predictor state and registers
   logic signed [31:0] kp, ki, kd, bias, tgt, integ, deriv, perr;
   logic [30:0] wlim;
   logic closed, armed;
   ctl_result_type expected_q[$];
   int mismatches = 0;
   int cycles = 0;
   int results_seen = 0;
   int long_stall_odds = 10;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
      if (x > 80'sd2147483647) return 32'sh7fffffff;
      if (x < -80'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // product of a gain and a word, floored by the fraction bits
   function automatic logic signed [79:0] gain_mul(input logic signed [31:0] g,
                                                   input logic signed [31:0] x);
      logic signed [79:0] p;
      p = 80'(g) * 80'(x);
      return p >>> FRAC_BITS;
   endfunction

   task automatic predict_beat(input logic [1:0] op, input logic signed [31:0] val,
                               input logic [19:0] el);
      logic signed [79:0] dt, acc, lim, sum;
      logic signed [31:0] err;
      dt = (el == 0) ? 80'sd1 : 80'(el);
      if (op == OP_MEAS) begin
         err = sat32(80'(tgt) - 80'(val));
         if (armed) begin
            lim = 80'(wlim);
            acc = 80'(integ) + (80'(err) * dt) / 80'sd1000000;
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ = acc[31:0];
            deriv = sat32(((80'(err) - 80'(perr)) * 80'sd1000000) / dt);
            perr = err;
         end else begin
            armed = 1'b1;
         end
         sum = gain_mul(kp, err) + gain_mul(ki, integ) + gain_mul(kd, deriv) + 80'(bias);
         expected_q.push_back('{sat32(sum), 1'b0});
      end else if (op == OP_SETPOINT) begin
         tgt = val;
         if (!closed) expected_q.push_back('{val, 1'b1});
      end else if (op == OP_CLEAR) begin
         integ = '0; deriv = '0; perr = '0; armed = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // result checker and stall generator
   always @(posedge clock) begin
      ctl_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_control_out, 32'h0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_control_out !== want.control_out)
                  report_mismatch("control_out", rsp_control_out, want.control_out);
               if (rsp_open_loop !== want.open_loop)
                  report_mismatch("open_loop", {31'b0, rsp_open_loop}, {31'b0, want.open_loop});
            end
         end
         if ($urandom_range(99) < long_stall_odds)
            rsp_stall <= ($urandom_range(99) < 5) ? 1'b1 : ~rsp_stall;
         else
            rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input reg_type idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_W'(4 * idx); pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_GAIN_P: kp = data;
         REG_GAIN_I: ki = data;
         REG_GAIN_D: kd = data;
         REG_WINDUP: wlim = data[30:0];
         REG_BIAS:   bias = data;
         REG_LOOP:   closed = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                           input logic [31:0] w, input logic [31:0] b, input logic lc);
      wait_idle();
      write_reg(REG_GAIN_P, p);
      write_reg(REG_GAIN_I, i);
      write_reg(REG_GAIN_D, d);
      write_reg(REG_WINDUP, w);
      write_reg(REG_BIAS, b);
      write_reg(REG_LOOP, {31'b0, lc});
   endtask

   task automatic send_beat(input logic [1:0] op, input logic signed [31:0] val,
                            input logic [19:0] el, input bit gaps);
      int gap;
      if (gaps) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
         repeat (gap) @(posedge clock);
      end
      @(posedge clock);
      req_valid <= 1'b1; req_operation <= op; req_value <= val; req_elapsed_us <= el;
      do @(posedge clock); while (req_stall);
      predict_beat(op, val, el);
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(262143)) - 32'd131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [19:0] rand_elapsed();
      case ($urandom_range(5))
         0: return 20'd0;
         1: return 20'hfffff;
         2: return 20'($urandom_range(2000));
         default: return 20'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      set_regs(32'h00010000, 32'h00008000, 32'h00000100, 32'h00100000, 32'h00000010, 1'b0);
      send_beat(OP_SETPOINT, 32'sh7fffffff, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh80000000, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh80000000, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh7fffffff, 20'hfffff, 0);
      send_beat(OP_UNUSED, 32'sh12345678, 20'd5, 0);
      send_beat(OP_MEAS, 32'sh00000000, 20'd1000, 0);
      send_beat(OP_CLEAR, 32'sh0, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh00010000, 20'd7, 0);
      send_beat(OP_SETPOINT, 32'sh80000000, 20'd1, 0);
      set_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1);
      send_beat(OP_SETPOINT, 32'sh7fffffff, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh80000000, 20'd1, 0);
      send_beat(OP_MEAS, 32'sh7fffffff, 20'd1, 0);
      send_beat(OP_MEAS, 32'sh80000000, 20'hfffff, 0);
      send_beat(OP_CLEAR, 32'sh0, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh0, 20'd0, 0);
      send_beat(OP_MEAS, 32'sh0, 20'd0, 0);
      set_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_beat(OP_MEAS, 32'sh5, 20'd3, 0);
      send_beat(OP_SETPOINT, 32'sh0, 20'd3, 0);
   endtask

   task automatic test_random(input int count);
      int n;
      logic [1:0] op;
      for (n = 0; n < count; n++) begin
         if (n % 150 == 0)
            set_regs(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     1'($urandom_range(1)));
         long_stall_odds = (n % 300 < 100) ? 0 : 30;
         case ($urandom_range(19))
            0: op = OP_CLEAR;
            1: op = OP_UNUSED;
            2, 3, 4: op = OP_SETPOINT;
            default: op = OP_MEAS;
         endcase
         send_beat(op, rand_word(), rand_elapsed(), (n % 300) >= 100);
      end
   endtask

   initial begin
      kp = 0; ki = 0; kd = 0; bias = 0; wlim = 0; closed = 0;
      tgt = 0; integ = 0; deriv = 0; perr = 0; armed = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1200);
      wait_idle();
      $display("covered directed extremes, all operations and %0d random beats", 1200);
      $display("%0d results checked over %0d cycles", results_seen, cycles);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
